>>> rtl/core/dlf_pkg.sv
// Package for the directory listing deframer.
// Phase and result-kind codes, the result record and result queue sizes.
// No dependencies.
package dlf_pkg;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_NLEN  = 3'd1,
    PH_NAME  = 3'd2,
    PH_FLAG  = 3'd3,
    PH_SIZE  = 3'd4,
    PH_TIME  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_t;

  localparam logic [7:0]  DIR_FLAG    = 8'd1;
  localparam logic [15:0] COUNT_BYTES = 16'd4;
  localparam logic [15:0] NLEN_BYTES  = 16'd2;
  localparam logic [15:0] WORD_BYTES  = 16'd8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic        last;
    logic [7:0]  name_byte;
    logic [31:0] entry_index;
    logic [15:0] name_length;
    logic        dir_flag;
    logic [63:0] entry_size;
    logic [63:0] mod_time;
    logic [31:0] entry_count;
  } result_t;

  typedef struct packed {
    logic first_vld;
    logic second_vld;
  } push_t;

endpackage

>>> rtl/core/dlf_queue.sv
// Result queue of the directory listing deframer: takes up to two results a
// cycle, delivers one per output transfer. Depends on dlf_pkg.
module dlf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  dlf_pkg::push_t   push,
  input  dlf_pkg::result_t first,
  input  dlf_pkg::result_t second,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output dlf_pkg::result_t head
);
  import dlf_pkg::*;

  result_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic [QPTR_W-1:0]   wr_ptr_plus;
  logic [QCNT_W-1:0]   push_n;
  logic                pop;

  assign pop         = out_valid && out_ready;
  assign push_n      = QCNT_W'(push.first_vld) + QCNT_W'(push.second_vld);
  assign wr_ptr_plus = wr_ptr_r + QPTR_W'(1);
  assign wr_ptr_nxt  = wr_ptr_r + QPTR_W'(push_n);
  assign rd_ptr_nxt  = rd_ptr_r + QPTR_W'(pop);
  assign count_nxt   = count_r + push_n - QCNT_W'(pop);
  assign room        = count_r <= QCNT_W'(QDEPTH - 2);
  assign out_valid   = count_r != '0;
  assign head        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      mem_r[wr_ptr_r] <= first;
    end
    if (push.second_vld) begin
      mem_r[wr_ptr_plus] <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/core/directory_listing_deframer.sv
// Top level of the directory listing deframer: byte parser and result queue.
// Depends on dlf_pkg and dlf_queue.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | data_byte, has_byte, end_of_buffer
//   out_    | output    | out_valid / out_ready| kind, last, name_byte, entry fields
//
// One input byte is taken per cycle while in_ready is high; its results enter the
// queue registers at the same edge. A byte with end of buffer may yield two
// results, which leave over two output transfers. in_ready holds while the queue
// has room for two results. Synchronous active-low reset clears parser and queue.
module directory_listing_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_last,
  output logic [7:0]  out_name_byte,
  output logic [31:0] out_entry_index,
  output logic [15:0] out_name_length,
  output logic        out_dir_flag,
  output logic [63:0] out_entry_size,
  output logic [63:0] out_mod_time,
  output logic [31:0] out_entry_count
);
  import dlf_pkg::*;

  phase_t      phase_r, phase_nxt, ph_step;
  logic [15:0] fcnt_r, fcnt_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic [31:0] done_r, done_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic        dir_r, dir_nxt;
  logic [63:0] size_r, size_nxt;
  logic [63:0] time_r, time_nxt;

  logic        acc, hb, eob;
  logic [15:0] cnt_inc;
  logic        count_last, nlen_last, name_last, word_last;
  logic [31:0] count_val, done_inc;
  logic [15:0] nlen_val;
  logic [63:0] size_val, time_val;

  logic        byte_vld, stat_vld;
  result_t     r_byte, r_stat, first, second, head;
  push_t       push;
  logic        room;

  assign acc        = in_valid && in_ready;
  assign hb         = acc && in_has_byte;
  assign eob        = acc && in_end_of_buffer;
  assign in_ready   = room;
  assign cnt_inc    = fcnt_r + 16'd1;
  assign count_last = cnt_inc == COUNT_BYTES;
  assign nlen_last  = cnt_inc == NLEN_BYTES;
  assign name_last  = cnt_inc == nlen_r;
  assign word_last  = cnt_inc == WORD_BYTES;
  assign count_val  = {decl_r[23:0], in_data_byte};
  assign nlen_val   = {nlen_r[7:0], in_data_byte};
  assign size_val   = {size_r[55:0], in_data_byte};
  assign time_val   = {time_r[55:0], in_data_byte};
  assign done_inc   = done_r + 32'd1;

  always_comb begin
    ph_step = phase_r;
    if (hb) begin
      unique case (phase_r)
        PH_COUNT: if (count_last) ph_step = (count_val == '0) ? PH_DONE : PH_NLEN;
        PH_NLEN:  if (nlen_last) ph_step = (nlen_val == '0) ? PH_FLAG : PH_NAME;
        PH_NAME:  if (name_last) ph_step = PH_FLAG;
        PH_FLAG:  ph_step = PH_SIZE;
        PH_SIZE:  if (word_last) ph_step = PH_TIME;
        PH_TIME:  if (word_last) ph_step = (done_inc == decl_r) ? PH_DONE : PH_NLEN;
        PH_DONE:  ph_step = PH_DONE;
        default:  ph_step = phase_r;
      endcase
    end
    phase_nxt = eob ? PH_COUNT : ph_step;
  end

  always_comb begin
    fcnt_nxt = fcnt_r;
    decl_nxt = decl_r;
    done_nxt = done_r;
    nlen_nxt = nlen_r;
    dir_nxt  = dir_r;
    size_nxt = size_r;
    time_nxt = time_r;
    byte_vld = 1'b0;
    r_byte   = '0;
    r_stat   = '0;
    if (hb) begin
      unique case (phase_r)
        PH_COUNT: begin
          decl_nxt = count_val;
          fcnt_nxt = count_last ? '0 : cnt_inc;
        end
        PH_NLEN: begin
          nlen_nxt = nlen_val;
          fcnt_nxt = nlen_last ? '0 : cnt_inc;
        end
        PH_NAME: begin
          byte_vld           = 1'b1;
          r_byte.kind        = KIND_NAME;
          r_byte.name_byte   = in_data_byte;
          r_byte.entry_index = done_r;
          fcnt_nxt           = name_last ? '0 : cnt_inc;
        end
        PH_FLAG: begin
          dir_nxt  = in_data_byte == DIR_FLAG;
          size_nxt = '0;
          time_nxt = '0;
          fcnt_nxt = '0;
        end
        PH_SIZE: begin
          size_nxt = size_val;
          fcnt_nxt = word_last ? '0 : cnt_inc;
        end
        PH_TIME: begin
          time_nxt = time_val;
          fcnt_nxt = word_last ? '0 : cnt_inc;
          if (word_last) begin
            byte_vld           = 1'b1;
            r_byte.kind        = KIND_ENTRY;
            r_byte.entry_index = done_r;
            r_byte.name_length = nlen_r;
            r_byte.dir_flag    = dir_r;
            r_byte.entry_size  = size_r;
            r_byte.mod_time    = time_val;
            nlen_nxt           = '0;
            done_nxt           = done_inc;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
    stat_vld           = eob;
    r_stat.kind        = (ph_step == PH_DONE) ? KIND_ACCEPT : KIND_TRUNC;
    r_stat.entry_index = done_nxt;
    r_stat.entry_count = (ph_step == PH_COUNT) ? '0 : decl_nxt;
    r_stat.last        = 1'b1;
    if (eob) begin
      fcnt_nxt = '0;
      decl_nxt = '0;
      done_nxt = '0;
      nlen_nxt = '0;
      dir_nxt  = 1'b0;
      size_nxt = '0;
      time_nxt = '0;
    end
  end

  always_comb begin
    push.first_vld  = byte_vld || stat_vld;
    push.second_vld = byte_vld && stat_vld;
    first           = byte_vld ? r_byte : r_stat;
    first.last      = !(byte_vld && stat_vld);
    second          = r_stat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      fcnt_r  <= '0;
      decl_r  <= '0;
      done_r  <= '0;
      nlen_r  <= '0;
      dir_r   <= 1'b0;
      size_r  <= '0;
      time_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      fcnt_r  <= fcnt_nxt;
      decl_r  <= decl_nxt;
      done_r  <= done_nxt;
      nlen_r  <= nlen_nxt;
      dir_r   <= dir_nxt;
      size_r  <= size_nxt;
      time_r  <= time_nxt;
    end
  end

  dlf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .first     (first),
    .second    (second),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind        = head.kind;
  assign out_last        = head.last;
  assign out_name_byte   = head.name_byte;
  assign out_entry_index = head.entry_index;
  assign out_name_length = head.name_length;
  assign out_dir_flag    = head.dir_flag;
  assign out_entry_size  = head.entry_size;
  assign out_mod_time    = head.mod_time;
  assign out_entry_count = head.entry_count;

endmodule

>>> rtl/core/dlf_checker.sv
// Port-level checks for the directory listing deframer, bound to the top level.
// Depends on dlf_pkg and directory_listing_deframer.
module dlf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic        out_last,
  input logic [7:0]  out_name_byte,
  input logic [15:0] out_name_length,
  input logic        out_dir_flag,
  input logic [63:0] out_entry_size,
  input logic [63:0] out_mod_time
);
  import dlf_pkg::*;

  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ACCEPT || out_kind == KIND_TRUNC) |-> out_last)
    else $error("buffer status not last");

  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ENTRY |->
      out_name_length == '0 && !out_dir_flag && out_entry_size == '0 &&
      out_mod_time == '0)
    else $error("entry fields set outside entry result");

  a_name_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_NAME |-> out_name_byte == '0)
    else $error("name byte set outside name result");

endmodule

bind directory_listing_deframer dlf_checker u_dlf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_last        (out_last),
  .out_name_byte   (out_name_byte),
  .out_name_length (out_name_length),
  .out_dir_flag    (out_dir_flag),
  .out_entry_size  (out_entry_size),
  .out_mod_time    (out_mod_time)
);

>>> tb/tb.sv
// Self-checking testbench for directory_listing_deframer.
// Drives random and directed listing buffers and checks every result against an
// in-bench parser. Depends on dlf_pkg and the deframer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dlf_pkg::*;

  localparam int TAIL_ITEMS  = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eob;
  } feed_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic        out_last;
  logic [7:0]  out_name_byte;
  logic [31:0] out_entry_index;
  logic [15:0] out_name_length;
  logic        out_dir_flag;
  logic [63:0] out_entry_size;
  logic [63:0] out_mod_time;
  logic [31:0] out_entry_count;

  directory_listing_deframer dut (.*);

  feed_item_t feed_q [$];
  logic [7:0] listing [$];
  result_t    expected_results [$];

  phase_t      ph;
  logic [15:0] fbc;
  logic [31:0] dcount;
  logic [31:0] done_cnt;
  logic [15:0] nlen;
  logic        dflag;
  logic [63:0] sz;
  logic [63:0] tm;

  int  in_count = 0;
  int  out_count = 0;
  int  mismatches = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  src_pct = 20;
  int  sink_pct = 20;
  int  hold_left = 0;
  bit  held = 1'b0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;
  int  n_names = 0;
  int  n_entries_seen = 0;
  int  n_accepted = 0;
  int  n_truncated = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_parser();
    ph       = PH_COUNT;
    fbc      = '0;
    dcount   = '0;
    done_cnt = '0;
    nlen     = '0;
    dflag    = 1'b0;
    sz       = '0;
    tm       = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic has, input logic eob);
    result_t r [2];
    int      n;
    n = 0;
    r[0] = '0;
    r[1] = '0;
    if (has) begin
      case (ph)
        PH_COUNT: begin
          dcount = {dcount[23:0], b};
          fbc = fbc + 16'd1;
          if (fbc == COUNT_BYTES) begin
            fbc = '0;
            ph = (dcount == 32'd0) ? PH_DONE : PH_NLEN;
          end
        end
        PH_NLEN: begin
          nlen = {nlen[7:0], b};
          fbc = fbc + 16'd1;
          if (fbc == NLEN_BYTES) begin
            fbc = '0;
            ph = (nlen == 16'd0) ? PH_FLAG : PH_NAME;
          end
        end
        PH_NAME: begin
          r[n].kind = KIND_NAME;
          r[n].name_byte = b;
          r[n].entry_index = done_cnt;
          n++;
          fbc = fbc + 16'd1;
          if (fbc == nlen) begin
            fbc = '0;
            ph = PH_FLAG;
          end
        end
        PH_FLAG: begin
          dflag = (b == DIR_FLAG);
          sz = '0;
          tm = '0;
          fbc = '0;
          ph = PH_SIZE;
        end
        PH_SIZE: begin
          sz = {sz[55:0], b};
          fbc = fbc + 16'd1;
          if (fbc == WORD_BYTES) begin
            fbc = '0;
            ph = PH_TIME;
          end
        end
        PH_TIME: begin
          tm = {tm[55:0], b};
          fbc = fbc + 16'd1;
          if (fbc == WORD_BYTES) begin
            r[n].kind = KIND_ENTRY;
            r[n].entry_index = done_cnt;
            r[n].name_length = nlen;
            r[n].dir_flag = dflag;
            r[n].entry_size = sz;
            r[n].mod_time = tm;
            n++;
            fbc = '0;
            nlen = '0;
            done_cnt = done_cnt + 32'd1;
            ph = (done_cnt == dcount) ? PH_DONE : PH_NLEN;
          end
        end
        default: ;
      endcase
    end
    if (eob) begin
      r[n].kind = (ph == PH_DONE) ? KIND_ACCEPT : KIND_TRUNC;
      r[n].entry_index = done_cnt;
      r[n].entry_count = (ph == PH_COUNT) ? 32'd0 : dcount;
      n++;
      clear_parser();
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) r[i].last = 1'b1;
      expected_results.insert(expected_results.size(), r[i]);
    end
  endtask

  task automatic put_be(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) listing.insert(listing.size(), v[8*i +: 8]);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_entry(input int nm_bytes);
    logic [7:0] flag;
    case ($urandom_range(0, 3))
      0: flag = 8'd0;
      1, 2: flag = DIR_FLAG;
      default: flag = 8'($urandom_range(0, 255));
    endcase
    put_be(nm_bytes, 2);
    repeat (nm_bytes) listing.insert(listing.size(), 8'($urandom_range(0, 255)));
    listing.insert(listing.size(), flag);
    put_be(pick_word(), 8);
    put_be(pick_word(), 8);
  endtask

  // drain the listing into the feed queue, closing it with an end marker
  task automatic emit_listing(input bit marker_alone, output int items);
    feed_item_t it;
    bit         alone;
    alone = marker_alone || (listing.size() == 0);
    items = 0;
    while (listing.size() > 0) begin
      if ($urandom_range(0, 99) < 3) begin
        it.data = 8'($urandom_range(0, 255));
        it.has = 1'b0;
        it.eob = 1'b0;
        feed_q.insert(feed_q.size(), it);
      end
      it.data = listing.pop_front();
      it.has = 1'b1;
      it.eob = (listing.size() == 0) && !alone;
      feed_q.insert(feed_q.size(), it);
      items++;
    end
    if (alone) begin
      it.data = 8'($urandom_range(0, 255));
      it.has = 1'b0;
      it.eob = 1'b1;
      feed_q.insert(feed_q.size(), it);
      items++;
    end
  endtask

  task automatic show(input string tag, input result_t r);
    $display("  %s kind=%0d last=%0b name_byte=%02h index=%0d nlen=%0d dir=%0b",
             tag, r.kind, r.last, r.name_byte, r.entry_index, r.name_length,
             r.dir_flag);
    $display("  %s size=%016h mtime=%016h count=%0d",
             tag, r.entry_size, r.mod_time, r.entry_count);
  endtask

  always @(posedge clk) begin
    feed_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= '0;
      in_has_byte <= 1'b0;
      in_end_of_buffer <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_data_byte, in_has_byte, in_end_of_buffer);
        in_count <= in_count + 1;
        if (in_count[6:0] == 7'd0) begin
          case ($urandom_range(0, 2))
            0: src_pct <= 0;
            1: src_pct <= 15;
            default: src_pct <= 40;
          endcase
        end
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          nxt = feed_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_has_byte <= nxt.has;
          in_end_of_buffer <= nxt.eob;
          if (!quiet && $urandom_range(0, 99) < src_pct) src_gap <= $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet <= (feed_q.size() <= TAIL_ITEMS);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '0;
        got.kind = kind_t'(out_kind);
        got.last = out_last;
        got.name_byte = out_name_byte;
        got.entry_index = out_entry_index;
        got.name_length = out_name_length;
        got.dir_flag = out_dir_flag;
        got.entry_size = out_entry_size;
        got.mod_time = out_mod_time;
        got.entry_count = out_entry_count;
        out_count <= out_count + 1;
        if (out_count[6:0] == 7'd0) begin
          case ($urandom_range(0, 2))
            0: sink_pct <= 0;
            1: sink_pct <= 15;
            default: sink_pct <= 40;
          endcase
        end
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: result transfer %0d arrived with nothing expected", out_count);
            show("actual  ", got);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.last !== want.last ||
              got.name_byte !== want.name_byte || got.entry_index !== want.entry_index ||
              got.name_length !== want.name_length ||
              got.dir_flag !== want.dir_flag ||
              got.entry_size !== want.entry_size ||
              got.mod_time !== want.mod_time ||
              got.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("tb: mismatch on result transfer %0d", out_count);
              show("expected", want);
              show("actual  ", got);
            end
          end
          case (want.kind)
            KIND_NAME:   n_names++;
            KIND_ENTRY:  n_entries_seen++;
            KIND_ACCEPT: n_accepted++;
            default:     n_truncated++;
          endcase
        end
      end
      if (!held && out_count == HOLD_AT) begin
        held <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < sink_pct) sink_gap <= $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_results.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    feed_item_t it;
    int         items;
    int         fed;
    int         mode;
    int         n_ent;
    int         cut;
    clear_parser();

    listing.delete();
    put_be(0, 4);
    emit_listing(1'b0, items);
    emit_listing(1'b1, items);
    it = '0;
    it.data = 8'hA5;
    feed_q.insert(feed_q.size(), it);
    put_be(1, 4);
    put_be(0, 2);
    listing.insert(listing.size(), DIR_FLAG);
    put_be('1, 8);
    put_be('0, 8);
    emit_listing(1'b0, items);

    fed = 0;
    while (fed < 1200) begin
      mode = $urandom_range(0, 99);
      listing.delete();
      if (mode < 90) begin
        n_ent = (mode < 5) ? 0 : $urandom_range(1, 3);
        put_be(n_ent, 4);
        repeat (n_ent) begin
          add_entry(($urandom_range(0, 4) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5));
        end
        if (mode >= 75) begin
          cut = $urandom_range(0, listing.size() - 1);
          while (listing.size() > cut) void'(listing.pop_back());
        end else if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) listing.insert(listing.size(), 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 40)) listing.insert(listing.size(), 8'($urandom_range(0, 255)));
      end
      emit_listing($urandom_range(0, 2) == 0, items);
      fed += items;
      if (fed >= 600 && fed - items < 600) begin
        listing.delete();
        put_be(1, 4);
        add_entry(300);
        emit_listing(1'b0, items);
        fed += items;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d input transfers over %0d buffers, %0d results checked",
             in_count, n_accepted + n_truncated, out_count);
    $display("tb: %0d name bytes, %0d entries, %0d accepted, %0d truncated buffers",
             n_names, n_entries_seen, n_accepted, n_truncated);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
